// ===== rtl/fgn_pkg.sv =====
package fgn_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FIX_W = 24;
    localparam int GRAD_SHIFT = 15;
    localparam int NOISE_W = 20;
    localparam int QUO_W = NOISE_W;
    localparam int AMP_W = 32;
    localparam int AMP_SUM_W = 36;
    localparam int TOTAL_W = 64;
    localparam int PROD_W = FIX_W + AMP_W + 1;
    localparam int FREQ_W = 32;
    localparam int FQ_DEPTH = 2;
    localparam int FQ_PTR_W = 1;

    typedef logic signed [FIX_W-1:0] fixed_t;

    localparam fixed_t FIX_ONE = FIX_W'(1 << FRAC_BITS);
    localparam fixed_t FADE_K6 = FIX_W'(6);
    localparam fixed_t FADE_K15 = FIX_W'(15 << FRAC_BITS);
    localparam fixed_t FADE_K10 = FIX_W'(10 << FRAC_BITS);

    localparam logic signed [NOISE_W-1:0] OUT_MAX = NOISE_W'(524287);
    localparam logic signed [NOISE_W-1:0] OUT_MIN = NOISE_W'(-524288);

    localparam logic [AMP_W-1:0] AMP_START = AMP_W'(32768);
    localparam logic [FREQ_W-1:0] FREQ_START = FREQ_W'(1 << FRAC_BITS);

    localparam logic [3:0] OCTAVES_RESET = 4'd1;
    localparam logic [15:0] PERSIST_RESET = 16'd16384;
    localparam logic [15:0] LACUN_RESET = 16'd8192;

    localparam logic [1:0] REG_OCTAVES = 2'd0;
    localparam logic [1:0] REG_PERSIST = 2'd1;
    localparam logic [1:0] REG_LACUN = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_PLAIN  = 2'd1,
        CMD_RIDGED = 2'd2,
        CMD_BILLOW = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [7:0]         idx;
        logic [7:0]         val;
    } item_t;

    typedef struct packed {
        logic [3:0]  octaves;
        logic [15:0] persistence;
        logic [15:0] lacunarity;
    } cfg_t;

    typedef struct packed {
        logic               start;
        cmd_t               mode;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [FREQ_W-1:0]  freq;
    } oct_req_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } tbl_wr_t;

    typedef struct packed {
        logic                 start;
        logic [TOTAL_W-1:0]   dividend;
        logic [AMP_SUM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
        logic             overflow;
    } div_rsp_t;

    typedef struct packed {
        logic signed [16:0] gx;
        logic signed [16:0] gy;
        logic signed [16:0] gz;
    } grad_t;

    localparam logic signed [16:0] G1 = 17'sd32768;
    localparam logic signed [16:0] NG1 = -17'sd32768;
    localparam logic signed [16:0] GH = 17'sd23170;
    localparam logic signed [16:0] NGH = -17'sd23170;
    localparam logic signed [16:0] GZ = 17'sd0;

    function automatic grad_t grad_vec(input logic [4:0] i);
        grad_t g;
        case (i)
            5'd0:  g = {G1, G1, GZ};
            5'd1:  g = {NG1, G1, GZ};
            5'd2:  g = {G1, NG1, GZ};
            5'd3:  g = {NG1, NG1, GZ};
            5'd4:  g = {G1, GZ, G1};
            5'd5:  g = {NG1, GZ, G1};
            5'd6:  g = {G1, GZ, NG1};
            5'd7:  g = {NG1, GZ, NG1};
            5'd8:  g = {GZ, G1, G1};
            5'd9:  g = {GZ, NG1, G1};
            5'd10: g = {GZ, G1, NG1};
            5'd11: g = {GZ, NG1, NG1};
            5'd12: g = {G1, G1, G1};
            5'd13: g = {NG1, G1, G1};
            5'd14: g = {G1, NG1, G1};
            5'd15: g = {NG1, NG1, G1};
            5'd16: g = {G1, G1, NG1};
            5'd17: g = {NG1, G1, NG1};
            5'd18: g = {G1, NG1, NG1};
            5'd19: g = {NG1, NG1, NG1};
            5'd20: g = {GZ, G1, GZ};
            5'd21: g = {GZ, NG1, GZ};
            5'd22: g = {G1, GZ, GZ};
            5'd23: g = {NG1, GZ, GZ};
            5'd24: g = {GZ, GZ, G1};
            5'd25: g = {GZ, GZ, NG1};
            5'd26: g = {GH, GH, GZ};
            5'd27: g = {NGH, GH, GZ};
            5'd28: g = {GH, NGH, GZ};
            5'd29: g = {NGH, NGH, GZ};
            5'd30: g = {GH, GZ, GH};
            default: g = {NGH, GZ, GH};
        endcase
        return g;
    endfunction

    function automatic fixed_t mulf(input fixed_t a, input fixed_t b);
        logic signed [2*FIX_W-1:0] p;
        p = a * b;
        p = p + (2*FIX_W)'(1 << (FRAC_BITS - 1));
        return p[FRAC_BITS+FIX_W-1:FRAC_BITS];
    endfunction

    function automatic fixed_t lerp(input fixed_t t, input fixed_t a, input fixed_t b);
        fixed_t d;
        d = b - a;
        return a + mulf(t, d);
    endfunction

    function automatic fixed_t grad(input logic [7:0] h, input fixed_t dx, input fixed_t dy,
                                    input fixed_t dz);
        grad_t g;
        logic signed [42:0] s;
        g = grad_vec(h[4:0]);
        s = $signed(g.gx) * dx + $signed(g.gy) * dy + $signed(g.gz) * dz;
        s = s + 43'sd16384;
        return s[GRAD_SHIFT+FIX_W-1:GRAD_SHIFT];
    endfunction

endpackage

// ===== rtl/fgn_front.sv =====
module fgn_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          command,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic signed [31:0]  coord_z,
    input  logic [7:0]          entry_index,
    input  logic [7:0]          entry_value,
    output logic                q_valid,
    output fgn_pkg::item_t      q_item,
    input  logic                q_pop
);

    fgn_pkg::item_t q_mem [fgn_pkg::FQ_DEPTH];
    fgn_pkg::item_t in_item;
    logic [fgn_pkg::FQ_PTR_W-1:0] wr_ptr_reg;
    logic [fgn_pkg::FQ_PTR_W-1:0] rd_ptr_reg;
    logic [fgn_pkg::FQ_PTR_W:0] cnt_reg;
    logic [fgn_pkg::FQ_PTR_W:0] cnt_next;
    logic push_ok;
    logic pop_ok;

    // Only the plain sum is three-dimensional; the other sums run at z = 0.
    always_comb
    begin
        in_item.cmd = fgn_pkg::cmd_t'(command);
        in_item.x = coord_x;
        in_item.y = coord_y;
        in_item.z = (fgn_pkg::cmd_t'(command) == fgn_pkg::CMD_PLAIN) ? coord_z : '0;
        in_item.idx = entry_index;
        in_item.val = entry_value;
    end

    assign full = (cnt_reg == (fgn_pkg::FQ_PTR_W + 1)'(fgn_pkg::FQ_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item = q_mem[rd_ptr_reg];
    assign push_ok = push && !full;
    assign pop_ok = q_pop && q_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push_ok && !pop_ok)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push_ok && pop_ok)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/fgn_octave.sv =====
module fgn_octave (
    input  logic                clk,
    input  logic                rst_n,
    input  fgn_pkg::oct_req_t   req,
    input  fgn_pkg::tbl_wr_t    tbl_wr,
    output logic                done,
    output fgn_pkg::fixed_t     val
);

    localparam int F = fgn_pkg::FRAC_BITS;

    logic [7:0] perm_mem [256];
    logic [7:0] rd0_reg;
    logic [7:0] rd1_reg;
    logic [7:0] rd_addr0;
    logic [7:0] rd_addr1;

    logic busy_reg;
    logic [3:0] step_reg;
    fgn_pkg::cmd_t mode_reg;
    logic [7:0] cell_reg [3];
    fgn_pkg::fixed_t fr_reg [3];
    fgn_pkg::fixed_t fc_reg [3];
    fgn_pkg::fixed_t ft_reg [3];
    fgn_pkg::fixed_t fade_reg [3];
    logic [7:0] b_reg;
    logic [7:0] aa_reg;
    logic [7:0] ab_reg;
    logic [7:0] ba_reg;
    logic [7:0] bb_reg;
    logic [7:0] hash_reg [8];
    fgn_pkg::fixed_t grad_reg [8];
    fgn_pkg::fixed_t lerp_reg [4];
    fgn_pkg::fixed_t n_reg [2];
    fgn_pkg::fixed_t r_reg;
    fgn_pkg::fixed_t val_reg;
    logic done_reg;

    logic signed [31:0] coord [3];
    logic signed [64:0] scaled [3];
    fgn_pkg::fixed_t dlo [3];
    fgn_pkg::fixed_t dhi [3];
    fgn_pkg::fixed_t r_abs;
    fgn_pkg::fixed_t ridge;
    fgn_pkg::fixed_t post_val;

    assign coord[0] = req.x;
    assign coord[1] = req.y;
    assign coord[2] = req.z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            scaled[i] = coord[i] * $signed({1'b0, req.freq});
            dlo[i] = fr_reg[i];
            dhi[i] = fr_reg[i] - fgn_pkg::FIX_ONE;
        end
    end

    // The hash chain: the first pairs of reads feed the addresses of later pairs, whose reads give the corner hashes.
    always_comb
    begin
        case (step_reg)
            4'd1:
            begin
                rd_addr0 = cell_reg[0];
                rd_addr1 = cell_reg[0] + 8'd1;
            end
            4'd2:
            begin
                rd_addr0 = rd0_reg + cell_reg[1];
                rd_addr1 = rd0_reg + cell_reg[1] + 8'd1;
            end
            4'd3:
            begin
                rd_addr0 = b_reg;
                rd_addr1 = b_reg + 8'd1;
            end
            4'd4:
            begin
                rd_addr0 = aa_reg;
                rd_addr1 = aa_reg + 8'd1;
            end
            4'd5:
            begin
                rd_addr0 = ba_reg;
                rd_addr1 = ba_reg + 8'd1;
            end
            4'd6:
            begin
                rd_addr0 = ab_reg;
                rd_addr1 = ab_reg + 8'd1;
            end
            4'd7:
            begin
                rd_addr0 = bb_reg;
                rd_addr1 = bb_reg + 8'd1;
            end
            default:
            begin
                rd_addr0 = cell_reg[0];
                rd_addr1 = cell_reg[0];
            end
        endcase
    end

    always_comb
    begin
        r_abs = r_reg[fgn_pkg::FIX_W-1] ? -r_reg : r_reg;
        ridge = fgn_pkg::FIX_ONE - r_abs;
        case (mode_reg)
            fgn_pkg::CMD_RIDGED: post_val = fgn_pkg::mulf(ridge, ridge);
            fgn_pkg::CMD_BILLOW: post_val = r_abs;
            default: post_val = r_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tbl_wr.en)
        begin
            perm_mem[tbl_wr.addr] <= tbl_wr.data;
        end
        rd0_reg <= perm_mem[rd_addr0];
        rd1_reg <= perm_mem[rd_addr1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
            mode_reg <= fgn_pkg::CMD_PLAIN;
            val_reg <= '0;
            r_reg <= '0;
            b_reg <= '0;
            aa_reg <= '0;
            ab_reg <= '0;
            ba_reg <= '0;
            bb_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                cell_reg[i] <= '0;
                fr_reg[i] <= '0;
                fc_reg[i] <= '0;
                ft_reg[i] <= '0;
                fade_reg[i] <= '0;
            end
            for (int k = 0; k < 8; k++)
            begin
                hash_reg[k] <= '0;
                grad_reg[k] <= '0;
            end
            for (int j = 0; j < 4; j++)
            begin
                lerp_reg[j] <= '0;
            end
            n_reg[0] <= '0;
            n_reg[1] <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (req.start)
                begin
                    busy_reg <= 1'b1;
                    step_reg <= 4'd1;
                    mode_reg <= req.mode;
                    for (int i = 0; i < 3; i++)
                    begin
                        cell_reg[i] <= scaled[i][2*F+7:2*F];
                        fr_reg[i] <= fgn_pkg::FIX_W'(scaled[i][2*F-1:F]);
                    end
                end
            end
            else
            begin
                step_reg <= step_reg + 4'd1;
                case (step_reg)
                    4'd1:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            fc_reg[i] <= fgn_pkg::mulf(fr_reg[i],
                                fgn_pkg::FADE_K6 * fr_reg[i] - fgn_pkg::FADE_K15)
                                + fgn_pkg::FADE_K10;
                            ft_reg[i] <= fgn_pkg::mulf(fr_reg[i], fr_reg[i]);
                        end
                    end
                    4'd2:
                    begin
                        b_reg <= rd1_reg + cell_reg[1];
                        for (int i = 0; i < 3; i++)
                        begin
                            ft_reg[i] <= fgn_pkg::mulf(ft_reg[i], fr_reg[i]);
                        end
                    end
                    4'd3:
                    begin
                        aa_reg <= rd0_reg + cell_reg[2];
                        ab_reg <= rd1_reg + cell_reg[2];
                        for (int i = 0; i < 3; i++)
                        begin
                            fade_reg[i] <= fgn_pkg::mulf(ft_reg[i], fc_reg[i]);
                        end
                    end
                    4'd4:
                    begin
                        ba_reg <= rd0_reg + cell_reg[2];
                        bb_reg <= rd1_reg + cell_reg[2];
                    end
                    4'd5:
                    begin
                        hash_reg[0] <= rd0_reg;
                        hash_reg[4] <= rd1_reg;
                    end
                    4'd6:
                    begin
                        hash_reg[1] <= rd0_reg;
                        hash_reg[5] <= rd1_reg;
                    end
                    4'd7:
                    begin
                        hash_reg[2] <= rd0_reg;
                        hash_reg[6] <= rd1_reg;
                    end
                    4'd8:
                    begin
                        hash_reg[3] <= rd0_reg;
                        hash_reg[7] <= rd1_reg;
                    end
                    4'd9:
                    begin
                        for (int k = 0; k < 8; k++)
                        begin
                            grad_reg[k] <= fgn_pkg::grad(hash_reg[k],
                                ((k & 1) != 0) ? dhi[0] : dlo[0],
                                ((k & 2) != 0) ? dhi[1] : dlo[1],
                                ((k & 4) != 0) ? dhi[2] : dlo[2]);
                        end
                    end
                    4'd10:
                    begin
                        for (int j = 0; j < 4; j++)
                        begin
                            lerp_reg[j] <= fgn_pkg::lerp(fade_reg[0], grad_reg[2*j],
                                                         grad_reg[2*j+1]);
                        end
                    end
                    4'd11:
                    begin
                        n_reg[0] <= fgn_pkg::lerp(fade_reg[1], lerp_reg[0], lerp_reg[1]);
                        n_reg[1] <= fgn_pkg::lerp(fade_reg[1], lerp_reg[2], lerp_reg[3]);
                    end
                    4'd12:
                    begin
                        r_reg <= fgn_pkg::lerp(fade_reg[2], n_reg[0], n_reg[1]);
                    end
                    4'd13:
                    begin
                        val_reg <= post_val;
                        done_reg <= 1'b1;
                        busy_reg <= 1'b0;
                        step_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign done = done_reg;
    assign val = val_reg;

endmodule

// ===== rtl/fgn_divider.sv =====
module fgn_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  fgn_pkg::div_req_t req,
    output fgn_pkg::div_rsp_t rsp
);

    localparam int QW = fgn_pkg::QUO_W;
    localparam int TW = fgn_pkg::TOTAL_W;

    logic busy_reg;
    logic [$clog2(QW)-1:0] cnt_reg;
    logic [TW-1:0] rem_reg;
    logic [TW-1:0] ds_reg;
    logic [QW-1:0] q_reg;
    logic ovf_reg;
    logic done_reg;
    logic [TW-1:0] limit;
    logic take;

    assign limit = TW'({req.divisor, QW'(0)});
    assign take = (rem_reg >= ds_reg);

    // A quotient that does not fit the result width is flagged at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            rem_reg <= '0;
            ds_reg <= '0;
            q_reg <= '0;
            ovf_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (req.start)
                begin
                    rem_reg <= req.dividend;
                    ds_reg <= TW'({req.divisor, (QW - 1)'(0)});
                    q_reg <= '0;
                    cnt_reg <= ($clog2(QW))'(QW - 1);
                    if (req.dividend >= limit)
                    begin
                        ovf_reg <= 1'b1;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        ovf_reg <= 1'b0;
                        busy_reg <= 1'b1;
                    end
                end
            end
            else
            begin
                if (take)
                begin
                    rem_reg <= rem_reg - ds_reg;
                end
                q_reg <= {q_reg[QW-2:0], take};
                ds_reg <= ds_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = q_reg;
    assign rsp.overflow = ovf_reg;

endmodule

// ===== rtl/fgn_back.sv =====
module fgn_back #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fgn_pkg::cfg_t        cfg,
    input  logic                 q_valid,
    input  fgn_pkg::item_t       q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_pop,
    output logic signed [fgn_pkg::NOISE_W-1:0] out_noise,
    output logic                 out_load,
    output logic                 out_sat
);

    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
    localparam int NW = fgn_pkg::NOISE_W;

    typedef enum logic [3:0] {
        B_IDLE,
        B_OCT_START,
        B_OCT_WAIT,
        B_MUL,
        B_ADD,
        B_DIV_PREP,
        B_DIV_START,
        B_DIV_WAIT,
        B_FINISH
    } back_state_t;

    back_state_t state_reg;
    fgn_pkg::item_t item_reg;
    logic [OCT_W-1:0] n_reg;
    logic [OCT_W-1:0] oct_cnt_reg;
    logic [OCT_W-1:0] n_next;
    logic [fgn_pkg::FREQ_W-1:0] freq_reg;
    logic [fgn_pkg::AMP_W-1:0] amp_reg;
    logic [fgn_pkg::AMP_SUM_W-1:0] amp_sum_reg;
    logic signed [fgn_pkg::TOTAL_W-1:0] total_reg;
    logic signed [fgn_pkg::PROD_W-1:0] prod_reg;
    fgn_pkg::fixed_t val_reg;
    logic [fgn_pkg::TOTAL_W-1:0] dvd_reg;
    logic signed [NW-1:0] res_noise_reg;
    logic res_load_reg;
    logic res_sat_reg;
    logic out_valid_reg;
    logic signed [NW-1:0] noise_reg;
    logic load_reg;
    logic sat_reg;

    fgn_pkg::oct_req_t oct_req;
    fgn_pkg::tbl_wr_t tbl_wr;
    logic oct_done;
    fgn_pkg::fixed_t oct_val;
    fgn_pkg::div_req_t div_req;
    fgn_pkg::div_rsp_t div_rsp;

    logic [47:0] amp_prod;
    logic [47:0] freq_prod;
    logic [35:0] freq_new;
    logic signed [fgn_pkg::PROD_W-1:0] prod_next;
    logic [fgn_pkg::TOTAL_W-1:0] mag;
    logic neg;
    logic [fgn_pkg::QUO_W-1:0] quo;
    logic signed [NW-1:0] clamp_val;
    logic clamp_sat;
    logic out_free;

    assign q_pop = (state_reg == B_IDLE) && q_valid;
    assign out_free = !out_valid_reg || out_pop;

    assign tbl_wr.en = q_pop && (q_item.cmd == fgn_pkg::CMD_LOAD);
    assign tbl_wr.addr = q_item.idx;
    assign tbl_wr.data = q_item.val;

    assign oct_req.start = (state_reg == B_OCT_START);
    assign oct_req.mode = item_reg.cmd;
    assign oct_req.x = item_reg.x;
    assign oct_req.y = item_reg.y;
    assign oct_req.z = item_reg.z;
    assign oct_req.freq = freq_reg;

    assign div_req.start = (state_reg == B_DIV_START);
    assign div_req.dividend = dvd_reg;
    assign div_req.divisor = amp_sum_reg;

    fgn_octave u_octave (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (oct_req),
        .tbl_wr (tbl_wr),
        .done   (oct_done),
        .val    (oct_val)
    );

    fgn_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        if (cfg.octaves == '0)
        begin
            n_next = OCT_W'(1);
        end
        else if (int'(cfg.octaves) > MAX_OCTAVES)
        begin
            n_next = OCT_W'(MAX_OCTAVES);
        end
        else
        begin
            n_next = OCT_W'(cfg.octaves);
        end
    end

    always_comb
    begin
        prod_next = val_reg * $signed({1'b0, amp_reg});
        amp_prod = amp_reg * cfg.persistence + 48'd16384;
        freq_prod = freq_reg * cfg.lacunarity + 48'd2048;
        freq_new = freq_prod[47:12];
        mag = total_reg[fgn_pkg::TOTAL_W-1] ? fgn_pkg::TOTAL_W'(-total_reg)
                                             : fgn_pkg::TOTAL_W'(total_reg);
        neg = total_reg[fgn_pkg::TOTAL_W-1];
        quo = div_rsp.quotient;
        if (!neg)
        begin
            clamp_sat = div_rsp.overflow || quo[fgn_pkg::QUO_W-1];
            clamp_val = clamp_sat ? fgn_pkg::OUT_MAX : NW'(quo);
        end
        else
        begin
            clamp_sat = div_rsp.overflow || (quo > fgn_pkg::QUO_W'(524288));
            clamp_val = clamp_sat ? fgn_pkg::OUT_MIN : NW'(-quo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            item_reg <= '0;
            n_reg <= '0;
            oct_cnt_reg <= '0;
            freq_reg <= '0;
            amp_reg <= '0;
            amp_sum_reg <= '0;
            total_reg <= '0;
            prod_reg <= '0;
            val_reg <= '0;
            dvd_reg <= '0;
            res_noise_reg <= '0;
            res_load_reg <= 1'b0;
            res_sat_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            noise_reg <= '0;
            load_reg <= 1'b0;
            sat_reg <= 1'b0;
        end
        else
        begin
            if (out_pop && !((state_reg == B_FINISH) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg <= q_item;
                        if (q_item.cmd == fgn_pkg::CMD_LOAD)
                        begin
                            res_noise_reg <= '0;
                            res_load_reg <= 1'b1;
                            res_sat_reg <= 1'b0;
                            state_reg <= B_FINISH;
                        end
                        else
                        begin
                            n_reg <= n_next;
                            oct_cnt_reg <= '0;
                            freq_reg <= fgn_pkg::FREQ_START;
                            amp_reg <= fgn_pkg::AMP_START;
                            amp_sum_reg <= '0;
                            total_reg <= '0;
                            state_reg <= B_OCT_START;
                        end
                    end
                end
                B_OCT_START:
                begin
                    state_reg <= B_OCT_WAIT;
                end
                B_OCT_WAIT:
                begin
                    if (oct_done)
                    begin
                        val_reg <= oct_val;
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    prod_reg <= prod_next;
                    amp_sum_reg <= amp_sum_reg + fgn_pkg::AMP_SUM_W'(amp_reg);
                    amp_reg <= amp_prod[fgn_pkg::AMP_W+14:15];
                    freq_reg <= (|freq_new[35:32]) ? '1 : freq_new[31:0];
                    state_reg <= B_ADD;
                end
                B_ADD:
                begin
                    total_reg <= total_reg + fgn_pkg::TOTAL_W'(prod_reg);
                    oct_cnt_reg <= oct_cnt_reg + 1'b1;
                    if (OCT_W'(oct_cnt_reg + 1'b1) == n_reg)
                    begin
                        state_reg <= B_DIV_PREP;
                    end
                    else
                    begin
                        state_reg <= B_OCT_START;
                    end
                end
                B_DIV_PREP:
                begin
                    dvd_reg <= mag + fgn_pkg::TOTAL_W'(amp_sum_reg >> 1);
                    state_reg <= B_DIV_START;
                end
                B_DIV_START:
                begin
                    state_reg <= B_DIV_WAIT;
                end
                B_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        res_noise_reg <= clamp_val;
                        res_load_reg <= 1'b0;
                        res_sat_reg <= clamp_sat;
                        state_reg <= B_FINISH;
                    end
                end
                B_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        noise_reg <= res_noise_reg;
                        load_reg <= res_load_reg;
                        sat_reg <= res_sat_reg;
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_noise = noise_reg;
    assign out_load = load_reg;
    assign out_sat = sat_reg;

    a_oct_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        oct_done |-> state_reg == B_OCT_WAIT)
        else $error("octave result outside of the wait state");

    a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == B_DIV_WAIT)
        else $error("quotient outside of the wait state");

    a_load_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && load_reg) |-> (noise_reg == '0 && !sat_reg))
        else $error("load item carries a noise value");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sat_reg) |->
        (noise_reg == fgn_pkg::OUT_MAX || noise_reg == fgn_pkg::OUT_MIN))
        else $error("saturated item not at a range limit");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_pop) |=> (out_valid_reg && $stable(noise_reg)))
        else $error("waiting result lost or changed");

endmodule

// ===== rtl/fractal_gradient_noise_unit.sv =====
// Fractal gradient noise unit.
// Input items enter through a queue port: an item is taken when push is high
// and full is low. A load command writes one permutation table entry; the
// three sum commands evaluate plain 3D, ridged 2D or billow 2D noise summed
// over the configured octaves and normalized by the sum of the amplitudes.
// Results leave through a queue port: the oldest result stands on the result
// ports while empty is low and is taken when pop is high.
// The front queue holds two items, so the sender keeps going while an item
// is being worked on; a stalled receiver fills the result register and then
// the front queue, after which full rises.
// A load result passes from the finish state into the result register.
// A sum runs the shared octave sequencer with its two-port table reads
// once per octave, then the bit-serial normalizing division and the result
// register, after the item has come through the front queue; the division
// skips its serial steps when the quotient does not fit the result width.
// The back end works on one item at a time.
// Reset clears the configuration registers to one octave, persistence 0.5
// and lacunarity 2.0 and empties all queues; the permutation table is not
// cleared and must be loaded before sums are requested.
module fractal_gradient_noise_unit #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          command,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic signed [31:0]  coord_z,
    input  logic [7:0]          entry_index,
    input  logic [7:0]          entry_value,
    output logic                empty,
    input  logic                pop,
    output logic signed [19:0]  noise_value,
    output logic                load_done,
    output logic                saturated,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [3:0] octaves_reg;
    logic [15:0] persist_reg;
    logic [15:0] lacun_reg;
    logic cfg_wr;
    fgn_pkg::cfg_t cfg;
    logic q_valid;
    fgn_pkg::item_t q_item;
    logic q_pop;
    logic out_valid;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octaves_reg <= fgn_pkg::OCTAVES_RESET;
            persist_reg <= fgn_pkg::PERSIST_RESET;
            lacun_reg <= fgn_pkg::LACUN_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                fgn_pkg::REG_OCTAVES: octaves_reg <= pwdata[3:0];
                fgn_pkg::REG_PERSIST: persist_reg <= pwdata[15:0];
                fgn_pkg::REG_LACUN: lacun_reg <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            fgn_pkg::REG_OCTAVES: prdata = {28'd0, octaves_reg};
            fgn_pkg::REG_PERSIST: prdata = {16'd0, persist_reg};
            fgn_pkg::REG_LACUN: prdata = {16'd0, lacun_reg};
            default: prdata = '0;
        endcase
    end

    assign cfg.octaves = octaves_reg;
    assign cfg.persistence = persist_reg;
    assign cfg.lacunarity = lacun_reg;

    fgn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    fgn_back #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_pop   (pop),
        .out_noise (noise_value),
        .out_load  (load_done),
        .out_sat   (saturated)
    );

    assign empty = !out_valid;

endmodule
